### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock edge, switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion on a clock edge that also holds across reset.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/lrm_pkg.sv
`timescale 1ns / 1ps

package lrm_pkg;

   // Defaults of the top-level parameters.
   localparam int MAX_FRAMES_DEF    = 65536;
   localparam int FRACTION_BITS_DEF = 16;

   // Fixed field widths.
   localparam int SAMPLE_W    = 16;
   localparam int FRAME_W     = 2 * SAMPLE_W;
   localparam int MODE_W      = 2;
   localparam int LOOP_W      = 17;
   localparam int PHASE_W     = 21;
   localparam int GAIN_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 21;

   localparam int MIN_LOOP   = 64;
   localparam int GAIN_ONE   = 32768;
   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MIX    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REWIND = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MIX_ENABLE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_FRAMES = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIX_GAIN    = 2'd3;

   // Register reset values.
   localparam logic [LOOP_W-1:0]  LOOP_FRAMES_RST = 17'd64;
   localparam logic [PHASE_W-1:0] PHASE_STEP_RST  = 21'd65536;
   localparam logic [GAIN_W-1:0]  MIX_GAIN_RST    = 16'd24576;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

endpackage

### hw/rtl/lrm_store.sv
`timescale 1ns / 1ps

module lrm_store import lrm_pkg::*; #(
   parameter int DEPTH = MAX_FRAMES_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                clock,
   input  store_ctl_type       ctl,
   input  logic [AW-1:0]       wr_addr,
   input  logic [FRAME_W-1:0]  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output logic [FRAME_W-1:0]  rd_data
);

   logic [FRAME_W-1:0] mem_ff [DEPTH];
   logic [FRAME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/looping_resample_mixer_core.sv
`timescale 1ns / 1ps
// Stereo loop mixer. The req channel carries items with a mode: a load item writes one
// Q1.15 stereo frame to the loop store at the load address, a mix item carries one game
// frame, and a rewind item sets play and load positions back to frame zero.
// Each mix item gives exactly one item on the rsp channel; load and rewind give none.
// Load, rewind and unused-mode items are taken one per cycle while the core is idle.
// A mix item with mixing off goes straight to the output step. With mixing on, it first
// passes the wrap steps, the store reads and, per channel, the difference multiply, sum,
// gain multiply and accumulate; the store is read twice and one shared multiplier runs
// four times (difference times fraction, then the sum times gain, for each channel). No
// new item is taken until the result has moved to the output register.
// A finished result sits in an output register; while the receiver stalls, load and
// rewind items are still taken, and a new mix result waits in the core until the
// output register is free. Write registers through the csr port only while idle; the
// core does not enforce it. Reset clears the positions, the registers and the output
// valid; the loop store is not cleared and must be loaded before it is played.

module looping_resample_mixer_core import lrm_pkg::*; #(
   parameter int MAX_FRAMES    = MAX_FRAMES_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic signed [SAMPLE_W-1:0] req_left_in,
   input  logic signed [SAMPLE_W-1:0] req_right_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_left_out,
   output logic signed [SAMPLE_W-1:0] rsp_right_out,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int FB         = FRACTION_BITS;
   localparam int AW         = $clog2(MAX_FRAMES);
   localparam int LEN_W      = $clog2(MAX_FRAMES + 1);
   localparam int STEP_INT_W = (PHASE_W > FB) ? PHASE_W - FB : 1;
   localparam int IDX_W      = ((LEN_W > STEP_INT_W) ? LEN_W : STEP_INT_W) + 1;
   localparam int CMP_W      = (LOOP_W > LEN_W) ? LOOP_W : LEN_W;
   localparam int VW         = SAMPLE_W + FB;
   localparam int MY_W       = SAMPLE_W + 2;
   localparam int PW         = VW + MY_W;
   localparam int SHIFT      = FB + 15;
   localparam int STEP_EXT_W = PHASE_W + FB;
   localparam logic [PW-1:0] TRUNC_BIAS = PW'({SHIFT{1'b1}});

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_WRAP_SUB = 4'd1;
   localparam logic [3:0] ST_WRAP_CLR = 4'd2;
   localparam logic [3:0] ST_RD_CUR   = 4'd3;
   localparam logic [3:0] ST_RD_NXT   = 4'd4;
   localparam logic [3:0] ST_MUL_DIFF = 4'd5;
   localparam logic [3:0] ST_SUM      = 4'd6;
   localparam logic [3:0] ST_MUL_GAIN = 4'd7;
   localparam logic [3:0] ST_ACC      = 4'd8;
   localparam logic [3:0] ST_OUT      = 4'd9;

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [SAMPLE_W+1:0] x
   );
      logic signed [SAMPLE_W+1:0] hi;
      logic signed [SAMPLE_W+1:0] lo;
      hi = (SAMPLE_W+2)'(SAMPLE_MAX);
      lo = (SAMPLE_W+2)'(SAMPLE_MIN);
      if (x > hi) begin
         return SAMPLE_W'(hi);
      end else if (x < lo) begin
         return SAMPLE_W'(lo);
      end
      return SAMPLE_W'(x);
   endfunction

   // Control state.
   logic [3:0]          state_ff, state_in;
   logic                ch_ff, ch_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [FB-1:0]       frac_ff, frac_in;
   logic [AW-1:0]       load_addr_ff, load_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                mix_enable_ff;
   logic [LOOP_W-1:0]   loop_frames_ff;
   logic [PHASE_W-1:0]  phase_step_ff;
   logic [GAIN_W-1:0]   mix_gain_ff;

   // Datapath registers.
   logic [AW-1:0]              nxt_addr_ff, nxt_addr_in;
   logic [FRAME_W-1:0]         cur_word_ff, cur_word_in;
   logic signed [VW-1:0]       v_ff, v_in;
   logic signed [PW-1:0]       mul_ff, mul_in;
   logic signed [SAMPLE_W-1:0] res_left_ff, res_left_in;
   logic signed [SAMPLE_W-1:0] res_right_ff, res_right_in;
   logic signed [SAMPLE_W-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_W-1:0] rsp_right_ff, rsp_right_in;

   // Combinational helpers.
   store_ctl_type              store_ctl;
   logic [AW-1:0]              rd_addr;
   logic [FRAME_W-1:0]         rd_data;
   logic [CMP_W-1:0]           frames_cmp;
   logic [IDX_W-1:0]           len_idx;
   logic [IDX_W-1:0]           idx_inc;
   logic [GAIN_W:0]            gain_c;
   logic [STEP_EXT_W-1:0]      step_ext;
   logic [FB-1:0]              step_frac;
   logic [IDX_W-1:0]           step_int;
   logic [FB:0]                fsum;
   logic signed [SAMPLE_W-1:0] a_s;
   logic signed [SAMPLE_W-1:0] b_s;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [VW-1:0]       a_sh;
   logic signed [VW-1:0]       mul_x;
   logic signed [MY_W-1:0]     mul_y;
   logic signed [PW-1:0]       mul_prod;
   logic signed [PW-1:0]       rounded;
   logic signed [PW-1:0]       shifted;
   logic signed [SAMPLE_W:0]   scaled;
   logic signed [SAMPLE_W-1:0] res_sel;
   logic signed [SAMPLE_W+1:0] mix_sum;
   logic signed [SAMPLE_W-1:0] mix_sat;

   lrm_store #(
      .DEPTH(MAX_FRAMES)
   ) u_lrm_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .wr_addr (load_addr_ff),
      .wr_data ({req_right_in, req_left_in}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

   always_comb begin
      store_ctl.wr_en = req_valid && req_ready && (req_mode == MODE_LOAD);
      store_ctl.rd_en = (state_ff == ST_RD_CUR) || (state_ff == ST_RD_NXT);
      rd_addr = (state_ff == ST_RD_CUR) ? idx_ff[AW-1:0] : nxt_addr_ff;
   end

   // Effective loop length and gain, clamped to their legal ranges.
   always_comb begin
      frames_cmp = CMP_W'(loop_frames_ff);
      if (frames_cmp < CMP_W'(MIN_LOOP)) begin
         len_idx = IDX_W'(MIN_LOOP);
      end else if (frames_cmp > CMP_W'(MAX_FRAMES)) begin
         len_idx = IDX_W'(MAX_FRAMES);
      end else begin
         len_idx = IDX_W'(frames_cmp);
      end
      gain_c = ({1'b0, mix_gain_ff} > (GAIN_W+1)'(GAIN_ONE)) ?
               (GAIN_W+1)'(GAIN_ONE) : {1'b0, mix_gain_ff};
   end

   always_comb begin
      step_ext  = STEP_EXT_W'(phase_step_ff);
      step_frac = step_ext[FB-1:0];
      step_int  = IDX_W'(step_ext >> FB);
      fsum      = {1'b0, frac_ff} + {1'b0, step_frac};
      idx_inc   = idx_ff + 1'b1;
   end

   // Shared multiplier: difference times fraction, then interpolated value times gain.
   always_comb begin
      a_s  = ch_ff ? cur_word_ff[FRAME_W-1:SAMPLE_W] : cur_word_ff[SAMPLE_W-1:0];
      b_s  = ch_ff ? rd_data[FRAME_W-1:SAMPLE_W] : rd_data[SAMPLE_W-1:0];
      diff = b_s - a_s;
      a_sh = {a_s, {FB{1'b0}}};
      if (state_ff == ST_MUL_GAIN) begin
         mul_x = v_ff;
         mul_y = signed'({1'b0, gain_c});
      end else begin
         mul_x = VW'(signed'({1'b0, frac_ff}));
         mul_y = MY_W'(diff);
      end
      mul_prod = mul_x * mul_y;
   end

   // Scale back with truncation toward zero, add the game sample and saturate.
   always_comb begin
      if (mul_ff[PW-1]) begin
         rounded = mul_ff + signed'(TRUNC_BIAS);
      end else begin
         rounded = mul_ff;
      end
      shifted = rounded >>> SHIFT;
      scaled  = (SAMPLE_W+1)'(shifted);
      res_sel = ch_ff ? res_right_ff : res_left_ff;
      mix_sum = res_sel + scaled;
      mix_sat = sat_sample(mix_sum);
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      load_addr_in = load_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      nxt_addr_in  = nxt_addr_ff;
      cur_word_in  = cur_word_ff;
      v_in         = v_ff;
      mul_in       = mul_ff;
      res_left_in  = res_left_ff;
      res_right_in = res_right_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  MODE_LOAD: begin
                     load_addr_in = (load_addr_ff == AW'(MAX_FRAMES - 1)) ?
                                    '0 : load_addr_ff + 1'b1;
                  end
                  MODE_MIX: begin
                     // The game samples wait in the result registers.
                     res_left_in  = req_left_in;
                     res_right_in = req_right_in;
                     ch_in        = 1'b0;
                     state_in     = mix_enable_ff ? ST_WRAP_SUB : ST_OUT;
                  end
                  MODE_REWIND: begin
                     idx_in       = '0;
                     frac_in      = '0;
                     load_addr_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WRAP_SUB: begin
            if (idx_ff >= len_idx) begin
               idx_in = idx_ff - len_idx;
            end
            state_in = ST_WRAP_CLR;
         end
         ST_WRAP_CLR: begin
            // Still past the end only when the loop was shortened while playing.
            if (idx_ff >= len_idx) begin
               idx_in = '0;
            end
            state_in = ST_RD_CUR;
         end
         ST_RD_CUR: begin
            nxt_addr_in = (idx_inc >= len_idx) ? '0 : idx_inc[AW-1:0];
            state_in    = ST_RD_NXT;
         end
         ST_RD_NXT: begin
            cur_word_in = rd_data;
            state_in    = ST_MUL_DIFF;
         end
         ST_MUL_DIFF: begin
            mul_in = mul_prod;
            // The fraction is an operand here, so it advances on the last channel.
            if (ch_ff) begin
               idx_in  = idx_ff + step_int + IDX_W'(fsum[FB]);
               frac_in = fsum[FB-1:0];
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            v_in     = a_sh + VW'(mul_ff);
            state_in = ST_MUL_GAIN;
         end
         ST_MUL_GAIN: begin
            mul_in   = mul_prod;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (ch_ff) begin
               res_right_in = mix_sat;
               state_in     = ST_OUT;
            end else begin
               res_left_in = mix_sat;
               ch_in       = 1'b1;
               state_in    = ST_MUL_DIFF;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = res_left_ff;
               rsp_right_in = res_right_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ch_ff          <= 1'b0;
         idx_ff         <= '0;
         frac_ff        <= '0;
         load_addr_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         mix_enable_ff  <= 1'b0;
         loop_frames_ff <= LOOP_FRAMES_RST;
         phase_step_ff  <= PHASE_STEP_RST;
         mix_gain_ff    <= MIX_GAIN_RST;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         idx_ff       <= idx_in;
         frac_ff      <= frac_in;
         load_addr_ff <= load_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MIX_ENABLE:  mix_enable_ff  <= csr_wdata[0];
               CSR_LOOP_FRAMES: loop_frames_ff <= csr_wdata[LOOP_W-1:0];
               CSR_PHASE_STEP:  phase_step_ff  <= csr_wdata[PHASE_W-1:0];
               CSR_MIX_GAIN:    mix_gain_ff    <= csr_wdata[GAIN_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      nxt_addr_ff  <= nxt_addr_in;
      cur_word_ff  <= cur_word_in;
      v_ff         <= v_in;
      mul_ff       <= mul_in;
      res_left_ff  <= res_left_in;
      res_right_ff <= res_right_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

endmodule

### hw/rtl/lrm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrm_checker import lrm_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [MODE_W-1:0]          req_mode,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_left_out,
   input logic signed [SAMPLE_W-1:0] rsp_right_out
);

   logic req_take;
   logic rsp_stall;

   assign req_take  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // No result is pending right after reset.
   `ASSERT_CLK(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   // Taking a mix item makes the core busy, so it is not ready for another item.
   `ASSERT_CLK_RST(a_mix_busy, clock, reset, (req_take && (req_mode == MODE_MIX)) |=> !req_ready, "ready right after a mix item")

   // Load, rewind and unused modes finish in the cycle they are taken and give no result.
   `ASSERT_CLK_RST(a_other_no_rsp, clock, reset, (req_take && (req_mode != MODE_MIX) && !rsp_valid) |=> (req_ready && !rsp_valid), "non-mix item gave a result or stalled")

   // A stalled result holds its value.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_stall |=> (rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out)), "stalled result changed")

endmodule

bind looping_resample_mixer_core lrm_checker u_lrm_checker (.*);
